// File: rtl/core/tsvf_pkg.sv
// Package for the typed sensor value to float converter.
// Tag codes, tag prefixes, default fraction, exponent bias and format enum. No dependencies.
`default_nettype none
package tsvf_pkg;
  localparam logic [31:0] TAG_FLT  = 32'h666C7420;
  localparam logic [31:0] TAG_UI8  = 32'h75693820;
  localparam logic [31:0] TAG_UI16 = 32'h75693136;
  localparam logic [15:0] PFX_SP   = 16'h7370;
  localparam logic [15:0] PFX_FP   = 16'h6670;
  localparam logic [3:0]  FRAC_DEFAULT = 4'd8;
  localparam logic [7:0]  EXP_BIAS = 8'd127;

  typedef enum logic [2:0] {
    FMT_NONE, FMT_FLT, FMT_SP, FMT_UI8, FMT_UI16, FMT_FP
  } fmt_t;
endpackage
`default_nettype wire

// File: rtl/core/typed_sensor_value_to_float.sv
// Typed sensor value to IEEE single converter, top level.
// Depends on tsvf_pkg.
`default_nettype none
// Decodes a four-character type tag and four value bytes into an IEEE 754
// single bit pattern. Four register stages: tag decode and magnitude, leading
// one position, normalize shift, pack. Accepts one transfer every cycle while
// the output is not stalled. A stage advances whenever it is empty or the stage
// after it moves, so a stall at the output holds all stages without loss.
module typed_sensor_value_to_float (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // type_tag[31:0], value_bytes[63:32]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata   // float_bits[31:0], type_known[32], zeros
);
  import tsvf_pkg::*;

  // stage 1: decode
  logic        v1, v2, v3, v4;
  fmt_t        fmt1;
  logic        sign1, known1;
  logic [15:0] mag1;
  logic [3:0]  frac1;
  logic [31:0] raw1;
  // stage 2: leading one
  logic        sign2, known2, pass2, zero2;
  logic [15:0] mag2;
  logic [3:0]  frac2, lz2;
  logic [31:0] raw2;
  // stage 3: normalize
  logic [31:0] bits3;
  logic        known3;
  logic        sign3, pass3, zero3;
  logic [14:0] man3;
  logic [7:0]  exp3;
  // stage 4: output
  logic [31:0] bits4;
  logic        known4;

  logic adv1, adv2, adv3, adv4;
  assign adv4 = !v4 || m_tready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign s_tready = adv1;

  logic [31:0] tag, vb;
  logic [15:0] u16;
  logic [7:0]  c4;
  logic [3:0]  frac_c;
  fmt_t        fmt_c;
  always_comb begin
    tag = s_tdata[31:0];
    vb  = s_tdata[63:32];
    u16 = vb[31:16];
    c4  = tag[7:0];
    if (c4 >= 8'h30 && c4 <= 8'h39) frac_c = 4'(c4 - 8'h30);
    else if (c4 >= 8'h61 && c4 <= 8'h66) frac_c = 4'(c4 - 8'h57);
    else frac_c = FRAC_DEFAULT;
    if (tag == TAG_FLT) fmt_c = FMT_FLT;
    else if (tag[31:16] == PFX_SP) fmt_c = FMT_SP;
    else if (tag == TAG_UI8) fmt_c = FMT_UI8;
    else if (tag == TAG_UI16) fmt_c = FMT_UI16;
    else if (tag[31:16] == PFX_FP) fmt_c = FMT_FP;
    else fmt_c = FMT_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= s_tvalid;
    end
    if (adv1) begin
      fmt1   <= fmt_c;
      known1 <= (fmt_c != FMT_NONE);
      raw1   <= {vb[7:0], vb[15:8], vb[23:16], vb[31:24]};
      case (fmt_c)
        FMT_SP: begin
          sign1 <= u16[15];
          mag1  <= u16[15] ? 16'(-u16) : u16;
          frac1 <= frac_c;
        end
        FMT_UI8: begin
          sign1 <= 1'b0;
          mag1  <= {8'd0, vb[31:24]};
          frac1 <= 4'd0;
        end
        FMT_UI16: begin
          sign1 <= 1'b0;
          mag1  <= u16;
          frac1 <= 4'd0;
        end
        FMT_FP: begin
          sign1 <= 1'b0;
          mag1  <= u16;
          frac1 <= frac_c;
        end
        default: begin
          sign1 <= 1'b0;
          mag1  <= 16'd0;
          frac1 <= 4'd0;
        end
      endcase
    end
  end

  logic [3:0] lz_c;
  always_comb begin
    lz_c = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (mag1[i]) lz_c = 4'(15 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2) begin
      sign2  <= sign1;
      known2 <= known1;
      pass2  <= (fmt1 == FMT_FLT);
      zero2  <= (mag1 == 16'd0);
      mag2   <= mag1;
      frac2  <= frac1;
      lz2    <= lz_c;
      raw2   <= raw1;
    end
  end

  logic [15:0] norm_c;
  assign norm_c = mag2 << lz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
    if (adv3) begin
      known3 <= known2;
      sign3  <= sign2;
      pass3  <= pass2;
      zero3  <= zero2;
      man3   <= norm_c[14:0];
      // exponent = bias + 15 - lz - frac, never below 127-15
      exp3   <= 8'(EXP_BIAS + 8'd15 - {4'd0, lz2} - {4'd0, frac2});
      bits3  <= raw2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv4) begin
      v4 <= v3;
    end
    if (adv4) begin
      known4 <= known3;
      if (pass3) bits4 <= bits3;
      else if (zero3) bits4 <= 32'd0;
      else bits4 <= {sign3, exp3, man3, 8'd0};
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {7'd0, known4, bits4};

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed during stall");
  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == 32'd0)
    else $error("unknown tag gave nonzero value");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !v3 && !v4 |=> !m_tvalid)
    else $error("output valid without an item in flight");
`endif
endmodule
`default_nettype wire

// File: test/typed_sensor_value_to_float_test.sv
// Testbench for the typed sensor value to float converter.
// Drives random and directed tag/value transfers, checks against a local predictor.
// Depends on tsvf_pkg and typed_sensor_value_to_float.
`default_nettype none
module typed_sensor_value_to_float_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tsvf_pkg::*;

  typedef struct packed {
    logic [31:0] float_bits;
    logic        type_known;
  } sensor_float_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  logic [63:0]   pending_items[$];
  sensor_float_t expected_floats[$];
  int  errors = 0;
  int  accepted = 0;
  int  received = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  bit  calm = 1'b0;
  bit  stim_done = 1'b0;
  bit  in_fire = 1'b0;

  always #10 clk = ~clk;

  typed_sensor_value_to_float DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Exact conversion of a 16-bit magnitude scaled by 2^-frac to single.
  function automatic logic [31:0] fixed_to_single(logic sign, logic [15:0] mag,
                                                   logic [3:0] frac);
    int lead;
    logic [22:0] mant;
    logic [7:0] expo;
    lead = 15;
    if (mag == 16'd0) return 32'd0;
    while (!mag[lead]) lead--;
    mant = 23'(({16'd0, mag} << (23 - lead)));
    expo = 8'(127 + lead - frac);
    return {sign, expo, mant};
  endfunction

  function automatic logic [3:0] frac_of_tag(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h61 + 10);
    return FRAC_DEFAULT;
  endfunction

  function automatic sensor_float_t decode_sensor(logic [31:0] tag, logic [31:0] v);
    sensor_float_t r;
    logic [15:0] u16;
    logic [15:0] mag;
    u16 = v[31:16];
    r.type_known = 1'b1;
    r.float_bits = '0;
    if (tag == TAG_FLT) begin
      r.float_bits = {v[7:0], v[15:8], v[23:16], v[31:24]};
    end else if (tag[31:16] == PFX_SP) begin
      mag = u16[15] ? 16'(-u16) : u16;
      r.float_bits = fixed_to_single(u16[15], mag, frac_of_tag(tag[7:0]));
    end else if (tag == TAG_UI8) begin
      r.float_bits = fixed_to_single(1'b0, {8'd0, v[31:24]}, 4'd0);
    end else if (tag == TAG_UI16) begin
      r.float_bits = fixed_to_single(1'b0, u16, 4'd0);
    end else if (tag[31:16] == PFX_FP) begin
      r.float_bits = fixed_to_single(1'b0, u16, frac_of_tag(tag[7:0]));
    end else begin
      r.type_known = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [31:0] random_tag();
    logic [7:0] c4;
    int k;
    k = $urandom_range(0, 9);
    c4 = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
         (($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h30, 8'h39))
                                      : 8'($urandom_range(8'h61, 8'h66)));
    case (k)
      0: return TAG_FLT;
      1: return TAG_UI8;
      2: return TAG_UI16;
      3, 4: return {PFX_SP, 8'($urandom), c4};
      5, 6: return {PFX_FP, 8'($urandom), c4};
      7: return TAG_FLT ^ (32'd1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // Driver: present the next pending item, with random bursts of idling, and random m_tready stalls.
  // in_fire is the input transfer seen at the last rising edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_fire && !calm && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 6);
      if (!s_tvalid || in_fire) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          s_tdata  <= pending_items.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 5);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on input transfers, compare on output transfers, idle watchdog.
  always @(posedge clk) begin
    sensor_float_t got, want;
    in_fire = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_floats.push_back(decode_sensor(s_tdata[31:0], s_tdata[63:32]));
        accepted++;
        in_fire = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[32]};
        received++;
        if (expected_floats.size() == 0) begin
          $display("%0t: unexpected result %h known %b", $time, got.float_bits,
                   got.type_known);
          errors++;
        end else begin
          want = expected_floats.pop_front();
          if (got.float_bits !== want.float_bits) begin
            $display("%0t: float_bits expected %h actual %h", $time,
                     want.float_bits, got.float_bits);
            errors++;
          end
          if (got.type_known !== want.type_known) begin
            $display("%0t: type_known expected %b actual %b", $time,
                     want.type_known, got.type_known);
            errors++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 2000) begin
        $display("%0t: watchdog expired", $time);
        $display("FAIL typed_sensor_value_to_float");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] hex_c[4];
    hex_c = '{8'h30, 8'h39, 8'h61, 8'h66};
    // Directed: pass-through incl. NaN/inf, extremes, every format, frac edges.
    pending_items.push_back({32'h0000803F, TAG_FLT});
    pending_items.push_back({32'h0000C07F, TAG_FLT});
    pending_items.push_back({32'h0000807F, TAG_FLT});
    pending_items.push_back({32'hFFFFFFFF, TAG_FLT});
    pending_items.push_back({32'h00000000, TAG_FLT});
    pending_items.push_back({32'h8000FFFF, {PFX_SP, 8'h37, 8'h38}});
    pending_items.push_back({32'h7FFFFFFF, {PFX_SP, 8'h00, 8'h30}});
    pending_items.push_back({32'hFFFF0000, {PFX_SP, 8'hFF, 8'h66}});
    pending_items.push_back({32'h0000FFFF, {PFX_SP, 8'h37, 8'h41}});
    pending_items.push_back({32'hFF000000, TAG_UI8});
    pending_items.push_back({32'h00FFFFFF, TAG_UI8});
    pending_items.push_back({32'hFFFFFFFF, TAG_UI16});
    pending_items.push_back({32'h00010000, TAG_UI16});
    pending_items.push_back({32'hFFFF0000, {PFX_FP, 8'h37, 8'h66}});
    pending_items.push_back({32'h0001FFFF, {PFX_FP, 8'h00, 8'h00}});
    for (int i = 0; i < 4; i++)
      pending_items.push_back({32'h8001AA55, {PFX_FP, 8'h31, hex_c[i]}});
    pending_items.push_back({32'h12345678, 32'h00000000});
    pending_items.push_back({32'h12345678, 32'hFFFFFFFF});
    pending_items.push_back({32'h12345678, TAG_UI16 ^ 32'h1});
    for (int i = 0; i < 1500; i++) begin
      if (i == 1300) begin
        wait (pending_items.size() == 0);
        calm = 1'b1;
      end
      pending_items.push_back({32'($urandom), random_tag()});
    end
    stim_done = 1'b1;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    wait (stim_done);
    wait (pending_items.size() == 0 && !s_tvalid);
    wait (expected_floats.size() == 0);
    repeat (20) @(posedge clk);
    $display("Checked %0d conversions over all tag formats, %0d results.",
             accepted, received);
    if (errors == 0 && expected_floats.size() == 0)
      $display("PASS typed_sensor_value_to_float");
    else
      $display("FAIL typed_sensor_value_to_float");
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
rtl/core/tsvf_pkg.sv
rtl/core/typed_sensor_value_to_float.sv
test/typed_sensor_value_to_float_test.sv
